/* rtl/median_filter_3x3_rgb_defines.svh */
// Assertion macros used by the checker.
`ifndef MEDIAN_FILTER_3X3_RGB_DEFINES_SVH
`define MEDIAN_FILTER_3X3_RGB_DEFINES_SVH

// Check a property on aclk, off while aresetn is low.
`define MF3_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on aclk, also while aresetn is low.
`define MF3_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/mf3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

    // Field widths
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int COL_OUT_W   = 10;
    localparam int ROW_W       = 12;
    localparam int FW_W        = 11;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;
    // Position arithmetic width: holds any row count plus one and any width
    localparam int EFF_W       = 13;
    localparam int NTAP        = 9;
    localparam int MED_IDX     = 4;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t  [NTAP-1:0] win_t;
    typedef chan_t [NTAP-1:0] taps_t;

    // Position info carried beside each result
    typedef struct packed {
        logic [COL_OUT_W-1:0] center_col;
        logic [ROW_W-1:0]     center_row;
        logic                 frame_last;
    } meta_t;

    // Load enables of the lane pipeline stages
    typedef struct packed {
        logic a;
        logic b;
    } lane_ld_t;

endpackage

`default_nettype wire

/* rtl/mf3_window.sv */
`timescale 1ns / 1ps
`default_nettype none

module mf3_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire mf3_pkg::pix_t                 s_pix,
    input  wire logic                          s_frame_start,
    input  wire logic [mf3_pkg::EFF_W-1:0]     w_eff,
    input  wire logic [mf3_pkg::ROW_W-1:0]     h_eff,
    input  wire logic                          rdy_a,
    output logic                               win_valid,
    output mf3_pkg::win_t                      win,
    output mf3_pkg::meta_t                     win_meta
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = mf3_pkg::EFF_W;
    localparam int RW = mf3_pkg::ROW_W;

    // Line stores, addressed by column
    mf3_pkg::pix_t older_mem [MAX_WIDTH];
    mf3_pkg::pix_t newer_mem [MAX_WIDTH];

    logic                  clr_reg;
    logic [CW-1:0]         clr_addr_reg;
    logic [CW-1:0]         col_cnt_reg;
    logic [RW-1:0]         row_cnt_reg;

    // Read stage
    logic                  v1_reg;
    logic                  wr_v_reg;
    logic [CW-1:0]         addr1_reg;
    mf3_pkg::pix_t         pix1_reg;
    mf3_pkg::pix_t         above1_reg;
    mf3_pkg::pix_t         above2_reg;
    logic                  emit1_reg;
    mf3_pkg::meta_t        meta1_reg;

    // Window stage
    logic                  vw_reg;
    mf3_pkg::win_t         win_reg;
    mf3_pkg::meta_t        metaw_reg;

    logic                  accept;
    logic                  rdy_w;
    logic                  ldw;
    logic [EW-1:0]         c0;
    logic [EW-1:0]         r0;
    logic [EW-1:0]         r1;
    logic [EW-1:0]         c_cur;
    logic [EW-1:0]         r_cur;
    logic [EW-1:0]         cn;
    logic [EW-1:0]         rn;
    logic [EW-1:0]         h_ext;
    logic [EW-1:0]         c_m1;
    logic [EW-1:0]         r_m1;
    logic                  wrap0;
    logic [CW-1:0]         cur_col;
    logic [CW-1:0]         col_next;
    logic [RW-1:0]         row_next;
    logic                  emit;
    mf3_pkg::meta_t        meta_cur;

    // Handshake: a stage loads when empty or when its item moves on
    assign rdy_w    = !vw_reg || rdy_a;
    assign ldw      = v1_reg && rdy_w;
    assign s_tready = (!v1_reg || rdy_w) && !clr_reg;
    assign accept   = s_tvalid && s_tready;

    // Place the incoming pixel and work out the position of the next one
    always_comb begin
        h_ext = EW'(h_eff);
        c0    = s_frame_start ? '0 : EW'(col_cnt_reg);
        r0    = s_frame_start ? '0 : EW'(row_cnt_reg);
        wrap0 = (c0 >= w_eff);
        c_cur = wrap0 ? '0 : c0;
        r1    = wrap0 ? r0 + EW'(1) : r0;
        r_cur = (r1 >= h_ext) ? '0 : r1;
        cn    = c_cur + EW'(1);
        rn    = r_cur + EW'(1);
        if (cn >= w_eff) begin
            col_next = '0;
            row_next = (rn >= h_ext) ? '0 : rn[RW-1:0];
        end else begin
            col_next = cn[CW-1:0];
            row_next = r_cur[RW-1:0];
        end
        cur_col = c_cur[CW-1:0];
        emit    = (c_cur >= EW'(2)) && (r_cur >= EW'(2));
        c_m1    = c_cur - EW'(1);
        r_m1    = r_cur - EW'(1);
        meta_cur.center_col = c_m1[mf3_pkg::COL_OUT_W-1:0];
        meta_cur.center_row = r_m1[RW-1:0];
        meta_cur.frame_last = (c_cur == w_eff - EW'(1)) && (r_cur == h_ext - EW'(1));
    end

    // Line stores: clear after reset, then read-and-shift per column
    always_ff @(posedge aclk) begin
        if (clr_reg) begin
            older_mem[clr_addr_reg] <= '0;
            newer_mem[clr_addr_reg] <= '0;
        end else begin
            if (accept) begin
                newer_mem[cur_col] <= s_pix;
                above1_reg         <= newer_mem[cur_col];
                // Forward the older-line write still pending at this column
                if (wr_v_reg && (addr1_reg == cur_col)) begin
                    above2_reg <= above1_reg;
                end else begin
                    above2_reg <= older_mem[cur_col];
                end
            end
            if (wr_v_reg) begin
                older_mem[addr1_reg] <= above1_reg;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            v1_reg       <= 1'b0;
            wr_v_reg     <= 1'b0;
            vw_reg       <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(MAX_WIDTH - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            wr_v_reg <= accept;
            if (accept) begin
                col_cnt_reg <= col_next;
                row_cnt_reg <= row_next;
            end
            if (accept) begin
                v1_reg <= 1'b1;
            end else if (ldw) begin
                v1_reg <= 1'b0;
            end
            // Drop border items here: only interior centres go on
            if (ldw) begin
                vw_reg <= emit1_reg;
            end else if (rdy_a) begin
                vw_reg <= 1'b0;
            end
        end
    end

    // Payload of the read stage and the window
    always_ff @(posedge aclk) begin
        if (accept) begin
            addr1_reg <= cur_col;
            pix1_reg  <= s_pix;
            emit1_reg <= emit;
            meta1_reg <= meta_cur;
        end
        if (ldw) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k * 3 + 0] <= win_reg[k * 3 + 1];
                win_reg[k * 3 + 1] <= win_reg[k * 3 + 2];
            end
            win_reg[2] <= above2_reg;
            win_reg[5] <= above1_reg;
            win_reg[8] <= pix1_reg;
            metaw_reg  <= meta1_reg;
        end
    end

    assign win_valid = vw_reg;
    assign win       = win_reg;
    assign win_meta  = metaw_reg;

endmodule

`default_nettype wire

/* rtl/mf3_lane.sv */
`timescale 1ns / 1ps
`default_nettype none

module mf3_lane (
    input  wire logic              aclk,
    input  wire mf3_pkg::lane_ld_t ld,
    input  wire mf3_pkg::taps_t    taps,
    output mf3_pkg::chan_t         med
);

    mf3_pkg::chan_t pa [mf3_pkg::NTAP];
    mf3_pkg::chan_t pb [mf3_pkg::NTAP];
    mf3_pkg::chan_t pc [mf3_pkg::NTAP];
    mf3_pkg::chan_t sa_reg [mf3_pkg::NTAP];
    mf3_pkg::chan_t sb_reg [mf3_pkg::NTAP];

    // Return {larger, smaller}
    function automatic logic [2*mf3_pkg::CH_W-1:0] sort2(input mf3_pkg::chan_t x,
                                                         input mf3_pkg::chan_t y);
        return (x > y) ? {x, y} : {y, x};
    endfunction

    // Sort each row of three
    always_comb begin
        for (int k = 0; k < mf3_pkg::NTAP; k++) begin
            pa[k] = taps[k];
        end
        {pa[2], pa[1]} = sort2(pa[1], pa[2]);
        {pa[5], pa[4]} = sort2(pa[4], pa[5]);
        {pa[8], pa[7]} = sort2(pa[7], pa[8]);
        {pa[1], pa[0]} = sort2(pa[0], pa[1]);
        {pa[4], pa[3]} = sort2(pa[3], pa[4]);
        {pa[7], pa[6]} = sort2(pa[6], pa[7]);
        {pa[2], pa[1]} = sort2(pa[1], pa[2]);
        {pa[5], pa[4]} = sort2(pa[4], pa[5]);
        {pa[8], pa[7]} = sort2(pa[7], pa[8]);
    end

    // Narrow down across rows
    always_comb begin
        for (int k = 0; k < mf3_pkg::NTAP; k++) begin
            pb[k] = sa_reg[k];
        end
        {pb[3], pb[0]} = sort2(pb[0], pb[3]);
        {pb[8], pb[5]} = sort2(pb[5], pb[8]);
        {pb[7], pb[4]} = sort2(pb[4], pb[7]);
        {pb[6], pb[3]} = sort2(pb[3], pb[6]);
        {pb[4], pb[1]} = sort2(pb[1], pb[4]);
        {pb[5], pb[2]} = sort2(pb[2], pb[5]);
        {pb[7], pb[4]} = sort2(pb[4], pb[7]);
    end

    // Final exchanges settle the middle value
    always_comb begin
        for (int k = 0; k < mf3_pkg::NTAP; k++) begin
            pc[k] = sb_reg[k];
        end
        {pc[2], pc[4]} = sort2(pc[4], pc[2]);
        {pc[4], pc[6]} = sort2(pc[6], pc[4]);
        {pc[2], pc[4]} = sort2(pc[4], pc[2]);
    end

    assign med = pc[mf3_pkg::MED_IDX];

    // Advance the network stages
    always_ff @(posedge aclk) begin
        if (ld.a) begin
            sa_reg <= pa;
        end
        if (ld.b) begin
            sb_reg <= pb;
        end
    end

endmodule

`default_nettype wire

/* rtl/mf3_merge.sv */
`timescale 1ns / 1ps
`default_nettype none

module mf3_merge (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          ld,
    input  wire mf3_pkg::chan_t                med0,
    input  wire mf3_pkg::chan_t                med1,
    input  wire mf3_pkg::chan_t                med2,
    input  wire mf3_pkg::meta_t                meta,
    output logic                               rdy_out,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mf3_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);

    localparam int PAD_W = mf3_pkg::M_TDATA_W - mf3_pkg::PIX_W
                           - mf3_pkg::COL_OUT_W - mf3_pkg::ROW_W;

    logic                             mv_reg;
    logic [mf3_pkg::M_TDATA_W-1:0]    tdata_reg;
    logic                             tlast_reg;

    assign rdy_out = !mv_reg || m_tready;

    // Hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (ld) begin
            mv_reg <= 1'b1;
        end else if (m_tready) begin
            mv_reg <= 1'b0;
        end
    end

    // Pack the three lane medians with the centre position
    always_ff @(posedge aclk) begin
        if (ld) begin
            tdata_reg <= {PAD_W'(0), meta.center_row, meta.center_col, med2, med1, med0};
            tlast_reg <= meta.frame_last;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

endmodule

`default_nettype wire

/* rtl/median_filter_3x3_rgb.sv */
`timescale 1ns / 1ps
`default_nettype none
// An accepted pixel passes the line store read, window shift, two network
// stages and the output register before its result beat shows on m_tvalid.
// Throughput: one pixel per cycle while m_tready and line store clearing allow.
// Reset: aresetn (synchronous, active low) clears control state and restores
// frame_width 640 / frame_height 480; then both line stores are zeroed, address
// by address up to MAX_WIDTH - 1, during which s_tready stays low.

module median_filter_3x3_rgb #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mf3_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [7:0] pix_ch0, [15:8] pix_ch1, [23:16] pix_ch2
    input  wire logic [mf3_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] frame_start
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] med_ch0, [15:8] med_ch1, [23:16] med_ch2, [33:24] center_col,
    // [45:34] center_row, [47:46] zero
    output logic [mf3_pkg::M_TDATA_W-1:0]          m_tdata,
    // frame_last
    output logic                                   m_tlast
);

    localparam int EW = mf3_pkg::EFF_W;

    logic [mf3_pkg::FW_W-1:0]   frame_width_reg;
    logic [mf3_pkg::ROW_W-1:0]  frame_height_reg;
    logic [EW-1:0]              w_eff;
    logic [mf3_pkg::ROW_W-1:0]  h_eff;

    logic                       win_valid;
    mf3_pkg::win_t              win;
    mf3_pkg::meta_t             win_meta;

    logic                       va_reg;
    logic                       vb_reg;
    mf3_pkg::meta_t             metaa_reg;
    mf3_pkg::meta_t             metab_reg;
    logic                       rdy_a;
    logic                       rdy_b;
    logic                       rdy_out;
    logic                       ld_out;
    mf3_pkg::lane_ld_t          lane_ld;
    mf3_pkg::chan_t             med [3];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= mf3_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= mf3_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mf3_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_data[mf3_pkg::FW_W-1:0];
                end
                mf3_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the width to what the line stores support and both sizes up to at least three
    always_comb begin
        if (frame_width_reg < mf3_pkg::FW_W'(3)) begin
            w_eff = EW'(3);
        end else if (EW'(frame_width_reg) > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(frame_width_reg);
        end
        h_eff = (frame_height_reg < mf3_pkg::ROW_W'(3)) ? mf3_pkg::ROW_W'(3)
                                                       : frame_height_reg;
    end

    mf3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_pix         (s_tdata),
        .s_frame_start (s_tuser),
        .w_eff         (w_eff),
        .h_eff         (h_eff),
        .rdy_a         (rdy_a),
        .win_valid     (win_valid),
        .win           (win),
        .win_meta      (win_meta)
    );

    // Lane pipeline handshake
    assign rdy_b     = !vb_reg || rdy_out;
    assign rdy_a     = !va_reg || rdy_b;
    assign ld_out    = vb_reg && rdy_out;
    assign lane_ld.a = win_valid && rdy_a;
    assign lane_ld.b = va_reg && rdy_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            if (lane_ld.a) begin
                va_reg <= 1'b1;
            end else if (lane_ld.b) begin
                va_reg <= 1'b0;
            end
            if (lane_ld.b) begin
                vb_reg <= 1'b1;
            end else if (ld_out) begin
                vb_reg <= 1'b0;
            end
        end
    end

    // Carry the position beside the lanes
    always_ff @(posedge aclk) begin
        if (lane_ld.a) begin
            metaa_reg <= win_meta;
        end
        if (lane_ld.b) begin
            metab_reg <= metaa_reg;
        end
    end

    // One median lane per channel
    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        mf3_pkg::taps_t taps;

        always_comb begin
            for (int k = 0; k < mf3_pkg::NTAP; k++) begin
                taps[k] = win[k][ch * mf3_pkg::CH_W +: mf3_pkg::CH_W];
            end
        end

        mf3_lane u_lane (
            .aclk (aclk),
            .ld   (lane_ld),
            .taps (taps),
            .med  (med[ch])
        );
    end

    mf3_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (ld_out),
        .med0     (med[0]),
        .med1     (med[1]),
        .med2     (med[2]),
        .meta     (metab_reg),
        .rdy_out  (rdy_out),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/mf3_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "median_filter_3x3_rgb_defines.svh"

module mf3_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [mf3_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                          m_tlast
);

    // A stalled result beat stays put
    `MF3_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")

    // Reset empties the output
    `MF3_ASSERT_RST(a_rst_empty, !aresetn |=> !m_tvalid, "result beat present after reset")

    // Line store clearing holds off input right after reset
    `MF3_ASSERT_CLK(a_clr_block, aresetn && !$past(aresetn) |-> !s_tready, "input taken during line store clear")

    // Centres are interior, so the reported row is never zero
    `MF3_ASSERT_CLK(a_row_interior, m_tvalid |-> m_tdata[45:34] != 12'd0, "border row reported as centre")

endmodule

bind median_filter_3x3_rgb mf3_checker u_mf3_checker (.*);

`default_nettype wire

/* tb/sv/mf3_median_checker.sv */
`timescale 1ns / 1ps

module mf3_median_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mf3_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    // [7:0] pix_ch0, [15:8] pix_ch1, [23:16] pix_ch2
    input  wire logic [mf3_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] frame_start
    input  wire logic                          s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    // [7:0] med_ch0, [15:8] med_ch1, [23:16] med_ch2, [33:24] center_col,
    // [45:34] center_row, [47:46] zero
    input  wire logic [mf3_pkg::M_TDATA_W-1:0] m_tdata,
    // frame_last
    input  wire logic                          m_tlast,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 pixels_in,
    output int                                 results_out,
    output int                                 frame_ends
);

    localparam int CH_W            = mf3_pkg::CH_W;
    localparam int PIX_W           = mf3_pkg::PIX_W;
    localparam int COL_OUT_W       = mf3_pkg::COL_OUT_W;
    localparam int ROW_W           = mf3_pkg::ROW_W;
    localparam int FW_W            = mf3_pkg::FW_W;
    localparam int M_TDATA_W       = mf3_pkg::M_TDATA_W;
    localparam int LINE_DEPTH      = 1024;
    localparam int WIDTH_AT_RESET  = 640;
    localparam int HEIGHT_AT_RESET = 480;
    localparam int REPORT_LIMIT    = 10;
    localparam int PENDING_DEPTH   = 64;

    typedef struct packed {
        mf3_pkg::chan_t       med0;
        mf3_pkg::chan_t       med1;
        mf3_pkg::chan_t       med2;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } median_beat_t;

    // ring of predicted beats, oldest at pend_head
    median_beat_t          pending_medians [PENDING_DEPTH];
    int                    pend_head;
    int                    pend_count;
    mf3_pkg::pix_t         row_above2 [LINE_DEPTH];
    mf3_pkg::pix_t         row_above1 [LINE_DEPTH];
    // three window columns, oldest first; each holds two rows up, one row up, current
    logic [2:0][PIX_W-1:0] win_col [3];
    logic [FW_W-1:0]       width_reg;
    logic [ROW_W-1:0]      height_reg;
    int                    col_pos;
    int                    row_pos;

    // Fifth smallest of nine: the value with at most four below it and at least five at or below
    function automatic mf3_pkg::chan_t median_of_nine(input logic [8:0][CH_W-1:0] v);
        int             lower;
        int             not_above;
        mf3_pkg::chan_t mid;
        mid = '0;
        for (int i = 0; i < 9; i++) begin
            lower = 0;
            not_above = 0;
            for (int j = 0; j < 9; j++) begin
                if (v[j] < v[i]) lower++;
                if (v[j] <= v[i]) not_above++;
            end
            if (lower <= 4 && not_above >= 5) mid = v[i];
        end
        return mid;
    endfunction

    function automatic mf3_pkg::chan_t channel_median(input int ch);
        logic [8:0][CH_W-1:0] taps;
        for (int k = 0; k < 9; k++)
            taps[k] = win_col[k / 3][k % 3][CH_W * ch +: CH_W];
        return median_of_nine(taps);
    endfunction

    // Append one predicted beat to the ring
    task automatic queue_median(input median_beat_t due);
        if (pend_count == PENDING_DEPTH) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: prediction ring overflow", $realtime);
        end else begin
            pending_medians[(pend_head + pend_count) % PENDING_DEPTH] = due;
            pend_count++;
        end
    endtask

    // Advance position, line stores and window by one pixel; queue a median for interior centers
    task automatic filter_pixel(input mf3_pkg::pix_t px, input logic first);
        int            w;
        int            h;
        int            c;
        int            r;
        mf3_pkg::pix_t up2;
        mf3_pkg::pix_t up1;
        median_beat_t  due;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = height_reg;
        if (h < 3) h = 3;

        if (first) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        up2 = row_above2[c];
        up1 = row_above1[c];
        row_above2[c] = up1;
        row_above1[c] = px;
        win_col[0] = win_col[1];
        win_col[1] = win_col[2];
        win_col[2] = {up2, up1, px};

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end

        if (c >= 2 && r >= 2) begin
            due.med0 = channel_median(0);
            due.med1 = channel_median(1);
            due.med2 = channel_median(2);
            due.col  = COL_OUT_W'(c - 1);
            due.row  = ROW_W'(r - 1);
            due.last = (c == w - 1) && (r == h - 1);
            queue_median(due);
        end
    endtask

    // Compare one output beat against the oldest queued median
    task automatic check_beat();
        median_beat_t want;
        median_beat_t got;
        logic         pad_bad;
        got.med0 = m_tdata[7:0];
        got.med1 = m_tdata[15:8];
        got.med2 = m_tdata[23:16];
        got.col  = m_tdata[33:24];
        got.row  = m_tdata[45:34];
        got.last = m_tlast;
        pad_bad  = |m_tdata[M_TDATA_W-1:46];
        results_out++;
        if (m_tlast) frame_ends++;

        if (pend_count == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: unexpected result beat, tdata %h tlast %b",
                         $realtime, m_tdata, m_tlast);
        end else begin
            want = pending_medians[pend_head];
            pend_head = (pend_head + 1) % PENDING_DEPTH;
            pend_count--;
            if (want.med0 != got.med0 || want.med1 != got.med1 || want.med2 != got.med2 ||
                want.col != got.col || want.row != got.row || want.last != got.last ||
                pad_bad) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"%0t: median mismatch, expected ch %h %h %h col %0d row %0d ",
                              "last %b, got ch %h %h %h col %0d row %0d last %b pad %h"},
                             $realtime, want.med0, want.med1, want.med2, want.col, want.row,
                             want.last, got.med0, got.med1, got.med2, got.col, got.row,
                             got.last, m_tdata[M_TDATA_W-1:46]);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = FW_W'(WIDTH_AT_RESET);
            height_reg = ROW_W'(HEIGHT_AT_RESET);
            col_pos    = 0;
            row_pos    = 0;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                row_above2[i] = '0;
                row_above1[i] = '0;
            end
            for (int i = 0; i < 3; i++) win_col[i] = '0;
            pend_head   = 0;
            pend_count  = 0;
            mismatches  = 0;
            pixels_in   = 0;
            results_out = 0;
            frame_ends  = 0;
        end else begin
            if (m_tvalid && m_tready) check_beat();
            if (cfg_we) begin
                case (cfg_index)
                    mf3_pkg::REG_FRAME_WIDTH: begin
                        width_reg = cfg_data[FW_W-1:0];
                    end
                    mf3_pkg::REG_FRAME_HEIGHT: begin
                        height_reg = cfg_data[ROW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                pixels_in++;
                filter_pixel(s_tdata, s_tuser);
            end
        end
        outstanding = pend_count;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT    = 4000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_PCT       = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CW             = mf3_pkg::CFG_W;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_we;
    logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [mf3_pkg::CFG_W-1:0]         cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [mf3_pkg::S_TDATA_W-1:0]     s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [mf3_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                              m_tlast;

    logic steady;
    logic rx_hold_req;
    int   mismatches;
    int   outstanding;
    int   pixels_in;
    int   results_out;
    int   frame_ends;
    int   quiet_cycles;
    int   run_w;
    int   run_h;

    median_filter_3x3_rgb #(
        .MAX_WIDTH(1024)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    mf3_median_checker u_median_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .outstanding(outstanding),
        .pixels_in  (pixels_in),
        .results_out(results_out),
        .frame_ends (frame_ends)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop the run when no beat moves and no register is written for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random back-pressure, or a long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge aclk);
                rx_hold_req = 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic mf3_pkg::pix_t rand_pix();
        mf3_pkg::pix_t px;
        int            pick;
        for (int ch = 0; ch < 3; ch++) begin
            pick = $urandom_range(0, 9);
            px[mf3_pkg::CH_W * ch +: mf3_pkg::CH_W] =
                (pick == 0) ? 8'h00 :
                (pick == 1) ? 8'hFF : mf3_pkg::chan_t'($urandom_range(0, 255));
        end
        return px;
    endfunction

    // Offer one pixel beat, with random gaps, and hold it until accepted
    task automatic send_pixel(input mf3_pkg::pix_t px, input logic first);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every queued median has come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    // Drain, then let pixels that make no result clear the pipeline
    task automatic wait_quiet();
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [mf3_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mf3_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // Reprogram the frame size while idle; keep the clamped size for shaping frames
    task automatic set_frame(input logic [mf3_pkg::CFG_W-1:0] w_val,
                             input logic [mf3_pkg::CFG_W-1:0] h_val);
        wait_quiet();
        write_reg(mf3_pkg::REG_FRAME_WIDTH, w_val);
        write_reg(mf3_pkg::REG_FRAME_HEIGHT, h_val);
        run_w = w_val[mf3_pkg::FW_W-1:0];
        if (run_w < 3) run_w = 3;
        if (run_w > 1024) run_w = 1024;
        run_h = h_val;
        if (run_h < 3) run_h = 3;
    endtask

    // Mostly whole frames with a start flag; some without it, some cut short with stray flags
    task automatic run_frames(input int count, input logic pause_mid);
        int mode;
        int len;
        for (int f = 0; f < count; f++) begin
            if (pause_mid && f == count / 2) wait_drain();
            mode = $urandom_range(0, 9);
            len  = (mode == 1) ? $urandom_range(1, run_w * run_h - 1) : run_w * run_h;
            for (int i = 0; i < len; i++)
                send_pixel(rand_pix(), (i == 0 && mode != 0) ||
                                       (mode == 1 && $urandom_range(0, 49) == 0));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        steady      = 1'b0;
        rx_hold_req = 1'b0;
        run_w       = 640;
        run_h       = 480;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Sizes from reset: a first row fragment, which yields no result
        for (int i = 0; i < 16; i++) send_pixel(rand_pix(), i == 0);

        // One whole frame with no idling on either side
        set_frame(12'd24, 12'd8);
        steady = 1'b1;
        for (int i = 0; i < 24 * 8; i++) send_pixel(rand_pix(), i == 0);
        steady = 1'b0;

        // Smallest frame: one interior pixel, extreme channel values
        set_frame(12'd3, 12'd3);
        for (int i = 0; i < 9; i++)
            send_pixel({(i % 2 == 1) ? 8'hFF : 8'h00, mf3_pkg::chan_t'(255 - 28 * i),
                        (i == 8) ? 8'hFF : mf3_pkg::chan_t'(28 * i)}, i == 0);
        // next frame begins by wrap-around, then restarts early on a start flag
        send_pixel(24'hFFFFFF, 1'b0);
        send_pixel(24'h000000, 1'b0);
        send_pixel(24'h807F01, 1'b0);
        for (int i = 0; i < 9; i++) send_pixel((i < 5) ? 24'h00FF00 : 24'hFF00FF, i == 0);

        // Register values below the minimum clamp up to three
        set_frame(12'h800, 12'h000);
        run_frames(8, 1'b0);

        // Random small sizes
        for (int p = 0; p < 5; p++) begin
            set_frame(CW'($urandom_range(3, 16)), CW'($urandom_range(3, 6)));
            run_frames($urandom_range(2, 3), p == 0);
        end

        // Shrink the frame while the position lies past the new size
        set_frame(12'd16, 12'd6);
        for (int i = 0; i < 58; i++) send_pixel(rand_pix(), i == 0);
        set_frame(12'd4, 12'd3);
        for (int i = 0; i < 30; i++) send_pixel(rand_pix(), 1'b0);

        // Tallest frame, then a height below the minimum from row thirty
        set_frame(12'd3, 12'hFFF);
        for (int i = 0; i < 90; i++) send_pixel(rand_pix(), i == 0);
        set_frame(12'd3, 12'h002);
        for (int i = 0; i < 20; i++) send_pixel(rand_pix(), 1'b0);

        // Wider frame; hold off the result side while the third row streams in
        set_frame(12'd64, 12'd3);
        for (int i = 0; i < 3 * 64 + 12; i++) begin
            if (i == 150) rx_hold_req = 1'b1;
            send_pixel(rand_pix(), i == 0);
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Covered %0d pixels and %0d median beats, %0d of them ending a frame,",
                 pixels_in, results_out, frame_ends);
        $display("at reset, clamped, shrunk, tallest and wider frame sizes.");
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_window.sv
rtl/mf3_lane.sv
rtl/mf3_merge.sv
rtl/median_filter_3x3_rgb.sv
rtl/mf3_checker.sv
tb/sv/mf3_median_checker.sv
tb/sv/testbench.sv
